### rtl/assert_macros.svh
// Assertion helpers used by the rational arithmetic unit.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS
// Checked property that is ignored while reset is high.
`define RAU_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("%m: assertion failed");
// Checked property that also holds across reset.
`define RAU_ASSERT_ALWAYS(label, clk, prop) \
   label: assert property (@(posedge clk) prop) \
      else $error("%m: assertion failed");
`else
`define RAU_ASSERT(label, clk, rst, prop)
`define RAU_ASSERT_ALWAYS(label, clk, prop)
`endif

`endif

### rtl/rau_pkg.sv
package rau_pkg;

   // Operation codes of a request.
   typedef enum logic [2:0] {
      MODE_ADD = 3'd0,
      MODE_SUB = 3'd1,
      MODE_MUL = 3'd2,
      MODE_DIV = 3'd3,
      MODE_INC = 3'd4,
      MODE_DEC = 3'd5
   } mode_type;

   // Sequencer states.
   typedef enum logic [3:0] {
      ST_IDLE,
      ST_INCDEC,
      ST_MUL0,
      ST_MUL1,
      ST_MUL2,
      ST_INIT,
      ST_EUC,
      ST_EUC_WAIT,
      ST_FIN,
      ST_QN_WAIT,
      ST_QD_WAIT,
      ST_RESP
   } state_type;

endpackage

### rtl/rau_req_if.sv
interface rau_req_if #(parameter int WIDTH = 16) ();
   logic                    valid;
   logic                    ready;
   logic [2:0]              mode;
   logic signed [WIDTH-1:0] a_num;
   logic signed [WIDTH-1:0] a_den;
   logic signed [WIDTH-1:0] b_num;
   logic signed [WIDTH-1:0] b_den;

   modport source (output valid, mode, a_num, a_den, b_num, b_den, input ready);
   modport sink   (input valid, mode, a_num, a_den, b_num, b_den, output ready);
endinterface

### rtl/rau_rsp_if.sv
interface rau_rsp_if #(parameter int WIDTH = 16) ();
   logic                      valid;
   logic                      ready;
   logic signed [2*WIDTH:0]   res_num;
   logic signed [2*WIDTH:0]   res_den;
   logic                      error;

   modport source (output valid, res_num, res_den, error, input ready);
   modport sink   (input valid, res_num, res_den, error, output ready);
endinterface

### rtl/rau_div.sv
// Restoring unsigned divider, one quotient bit per cycle.
module rau_div #(
   parameter int N = 32
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   input  logic [N-1:0] dividend,
   input  logic [N-1:0] divisor,
   output logic [N-1:0] quotient,
   output logic [N-1:0] remainder,
   output logic         done
);
   localparam int CW = $clog2(N + 1);

   logic [N-1:0] rem_ff, rem_in;
   logic [N-1:0] quo_ff, quo_in;
   logic [N-1:0] dvs_ff, dvs_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic busy_ff, busy_in;
   logic done_ff, done_in;
   logic [N:0] shifted;
   logic [N:0] diff;

   // One trial subtraction per cycle.
   always_comb begin
      shifted = {rem_ff, quo_ff[N-1]};
      diff    = shifted - {1'b0, dvs_ff};
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dvs_in  = dvs_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in  = '0;
         quo_in  = dividend;
         dvs_in  = divisor;
         cnt_in  = CW'(N);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in = diff[N] ? shifted[N-1:0] : diff[N-1:0];
         quo_in = {quo_ff[N-2:0], ~diff[N]};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
      if (reset) begin
         cnt_ff  <= '0;
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign quotient  = quo_ff;
   assign remainder = rem_ff;
   assign done      = done_ff;
endmodule

### rtl/rational_arithmetic_unit.sv
// Rational arithmetic unit: adds, subtracts, multiplies or divides two signed fractions and
// reduces the result by a Euclid divisor, or increments or decrements the first fraction.
// One request is in work at a time and req_ch.ready is high only while idle. Increment and
// decrement compute the result in ST_INCDEC; unused codes go to the response with error set.
// The four arithmetic operations form the products and set up the Euclid registers, then
// run each Euclid remainder step on the single shared bit-serial divider, followed by the
// last Euclid check and the two final quotients. A zero reduction divisor returns 0/0 with
// error set and skips the quotients.
module rational_arithmetic_unit
   import rau_pkg::*;
#(
   parameter int WIDTH = 16
) (
   input  logic clock,
   input  logic reset,
   rau_req_if.sink   req_ch,
   rau_rsp_if.source rsp_ch
);
`include "assert_macros.svh"

   localparam int PW = 2 * WIDTH;
   localparam int OW = 2 * WIDTH + 1;

   state_type state_ff, state_in;
   logic [2:0]       mode_ff, mode_in;
   logic [WIDTH-1:0] an_ff, an_in, ad_ff, ad_in, bn_ff, bn_in, bd_ff, bd_in;
   logic [PW-1:0]    x_mag_ff, x_mag_in, y_mag_ff, y_mag_in;
   logic             x_neg_ff, x_neg_in, y_neg_ff, y_neg_in;
   logic [PW-1:0]    num_mag_ff, num_mag_in, den_mag_ff, den_mag_in;
   logic             num_neg_ff, num_neg_in, den_neg_ff, den_neg_in;
   logic [PW-1:0]    ea_ff, ea_in, eb_ff, eb_in, qn_ff, qn_in;
   logic             eb_neg_ff, eb_neg_in, del_neg_ff, del_neg_in;
   logic [OW-1:0]    res_num_ff, res_num_in, res_den_ff, res_den_in;
   logic             err_ff, err_in;

   logic             an_neg, ad_neg, bn_neg, bd_neg;
   logic [WIDTH-1:0] an_mag, ad_mag, bn_mag, bd_mag;
   logic [WIDTH-1:0] mul_a, mul_b;
   logic             mul_neg;
   logic [PW-1:0]    product;
   logic             sy_neg;
   logic [PW-1:0]    sum_mag;
   logic             sum_neg;
   logic             div_start, div_done;
   logic [PW-1:0]    div_dvd, div_dvs, div_quo, div_rem;

   // Convert a sign and magnitude to a two's complement result.
   function automatic logic [OW-1:0] to_twos(input logic neg, input logic [PW-1:0] mag);
      logic [OW-1:0] ext;
      ext = {1'b0, mag};
      return neg ? (~ext + 1'b1) : ext;
   endfunction

   // Sign and magnitude of the captured operands.
   always_comb begin
      an_neg = an_ff[WIDTH-1];
      ad_neg = ad_ff[WIDTH-1];
      bn_neg = bn_ff[WIDTH-1];
      bd_neg = bd_ff[WIDTH-1];
      an_mag = an_neg ? (~an_ff + 1'b1) : an_ff;
      ad_mag = ad_neg ? (~ad_ff + 1'b1) : ad_ff;
      bn_mag = bn_neg ? (~bn_ff + 1'b1) : bn_ff;
      bd_mag = bd_neg ? (~bd_ff + 1'b1) : bd_ff;
   end

   // Shared multiplier; the operand pair depends on the step and the operation.
   always_comb begin
      mul_a   = ad_mag;
      mul_b   = bd_mag;
      mul_neg = ad_neg ^ bd_neg;
      unique case (state_ff)
         ST_MUL0: begin
            mul_a = an_mag;
            if (mode_ff == MODE_MUL) begin
               mul_b   = bn_mag;
               mul_neg = an_neg ^ bn_neg;
            end else begin
               mul_b   = bd_mag;
               mul_neg = an_neg ^ bd_neg;
            end
         end
         ST_MUL1: begin
            if (mode_ff == MODE_DIV) begin
               mul_a   = ad_mag;
               mul_b   = bn_mag;
               mul_neg = ad_neg ^ bn_neg;
            end else if (mode_ff != MODE_MUL) begin
               mul_a   = bn_mag;
               mul_b   = ad_mag;
               mul_neg = bn_neg ^ ad_neg;
            end
         end
         default: begin
         end
      endcase
      product = PW'(mul_a) * PW'(mul_b);
   end

   // Signed-magnitude sum or difference of the two cross products.
   always_comb begin
      sy_neg = y_neg_ff ^ (mode_ff == MODE_SUB);
      if (x_neg_ff == sy_neg) begin
         sum_mag = x_mag_ff + y_mag_ff;
         sum_neg = x_neg_ff;
      end else if (x_mag_ff >= y_mag_ff) begin
         sum_mag = x_mag_ff - y_mag_ff;
         sum_neg = x_neg_ff;
      end else begin
         sum_mag = y_mag_ff - x_mag_ff;
         sum_neg = sy_neg;
      end
   end

   // Sequencer: next state, datapath updates and divider control.
   always_comb begin
      state_in   = state_ff;
      mode_in    = mode_ff;
      an_in      = an_ff;
      ad_in      = ad_ff;
      bn_in      = bn_ff;
      bd_in      = bd_ff;
      x_mag_in   = x_mag_ff;
      x_neg_in   = x_neg_ff;
      y_mag_in   = y_mag_ff;
      y_neg_in   = y_neg_ff;
      num_mag_in = num_mag_ff;
      num_neg_in = num_neg_ff;
      den_mag_in = den_mag_ff;
      den_neg_in = den_neg_ff;
      ea_in      = ea_ff;
      eb_in      = eb_ff;
      eb_neg_in  = eb_neg_ff;
      del_neg_in = del_neg_ff;
      qn_in      = qn_ff;
      res_num_in = res_num_ff;
      res_den_in = res_den_ff;
      err_in     = err_ff;
      div_start  = 1'b0;
      div_dvd    = ea_ff;
      div_dvs    = ea_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_ch.valid) begin
               mode_in = req_ch.mode;
               an_in   = req_ch.a_num;
               ad_in   = req_ch.a_den;
               bn_in   = req_ch.b_num;
               bd_in   = req_ch.b_den;
               unique case (req_ch.mode) inside
                  MODE_INC, MODE_DEC: state_in = ST_INCDEC;
                  MODE_ADD, MODE_SUB, MODE_MUL, MODE_DIV: state_in = ST_MUL0;
                  default: begin
                     res_num_in = '0;
                     res_den_in = '0;
                     err_in     = 1'b1;
                     state_in   = ST_RESP;
                  end
               endcase
            end
         end
         ST_INCDEC: begin
            if (mode_ff == MODE_INC) begin
               res_num_in = OW'(signed'(an_ff)) + OW'(signed'(ad_ff));
            end else begin
               res_num_in = OW'(signed'(an_ff)) - OW'(signed'(ad_ff));
            end
            res_den_in = OW'(signed'(ad_ff));
            err_in     = 1'b0;
            state_in   = ST_RESP;
         end
         ST_MUL0: begin
            x_mag_in = product;
            x_neg_in = mul_neg;
            state_in = ST_MUL1;
         end
         ST_MUL1: begin
            if (mode_ff == MODE_MUL || mode_ff == MODE_DIV) begin
               den_mag_in = product;
               den_neg_in = mul_neg;
               num_mag_in = x_mag_ff;
               num_neg_in = x_neg_ff;
               state_in   = ST_INIT;
            end else begin
               y_mag_in = product;
               y_neg_in = mul_neg;
               state_in = ST_MUL2;
            end
         end
         ST_MUL2: begin
            den_mag_in = product;
            den_neg_in = mul_neg;
            num_mag_in = sum_mag;
            num_neg_in = sum_neg;
            state_in   = ST_INIT;
         end
         ST_INIT: begin
            ea_in      = num_mag_ff;
            del_neg_in = num_neg_ff;
            eb_in      = den_mag_ff;
            eb_neg_in  = den_neg_ff;
            state_in   = ST_EUC;
         end
         ST_EUC: begin
            if (eb_ff == '0) begin
               state_in = ST_FIN;
            end else begin
               div_start = 1'b1;
               div_dvd   = ea_ff;
               div_dvs   = eb_ff;
               state_in  = ST_EUC_WAIT;
            end
         end
         ST_EUC_WAIT: begin
            if (div_done) begin
               ea_in      = eb_ff;
               del_neg_in = eb_neg_ff;
               eb_in      = div_rem;
               eb_neg_in  = 1'b0;
               state_in   = ST_EUC;
            end
         end
         ST_FIN: begin
            if (ea_ff == '0) begin
               res_num_in = '0;
               res_den_in = '0;
               err_in     = 1'b1;
               state_in   = ST_RESP;
            end else begin
               div_start = 1'b1;
               div_dvd   = num_mag_ff;
               state_in  = ST_QN_WAIT;
            end
         end
         ST_QN_WAIT: begin
            if (div_done) begin
               qn_in     = div_quo;
               div_start = 1'b1;
               div_dvd   = den_mag_ff;
               state_in  = ST_QD_WAIT;
            end
         end
         ST_QD_WAIT: begin
            if (div_done) begin
               res_num_in = to_twos(num_neg_ff ^ del_neg_ff, qn_ff);
               res_den_in = to_twos(den_neg_ff ^ del_neg_ff, div_quo);
               err_in     = 1'b0;
               state_in   = ST_RESP;
            end
         end
         ST_RESP: begin
            if (rsp_ch.ready) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      mode_ff    <= mode_in;
      an_ff      <= an_in;
      ad_ff      <= ad_in;
      bn_ff      <= bn_in;
      bd_ff      <= bd_in;
      x_mag_ff   <= x_mag_in;
      x_neg_ff   <= x_neg_in;
      y_mag_ff   <= y_mag_in;
      y_neg_ff   <= y_neg_in;
      num_mag_ff <= num_mag_in;
      num_neg_ff <= num_neg_in;
      den_mag_ff <= den_mag_in;
      den_neg_ff <= den_neg_in;
      ea_ff      <= ea_in;
      eb_ff      <= eb_in;
      eb_neg_ff  <= eb_neg_in;
      del_neg_ff <= del_neg_in;
      qn_ff      <= qn_in;
      res_num_ff <= res_num_in;
      res_den_ff <= res_den_in;
      err_ff     <= err_in;
   end

   // Shared divider for the Euclid remainders and the final quotients.
   rau_div #(.N(PW)) u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (div_dvd),
      .divisor   (div_dvs),
      .quotient  (div_quo),
      .remainder (div_rem),
      .done      (div_done)
   );

   // Handshake outputs.
   assign req_ch.ready   = (state_ff == ST_IDLE);
   assign rsp_ch.valid   = (state_ff == ST_RESP);
   assign rsp_ch.res_num = res_num_ff;
   assign rsp_ch.res_den = res_den_ff;
   assign rsp_ch.error   = err_ff;

   `RAU_ASSERT(a_no_overlap, clock, reset, rsp_ch.valid |-> !req_ch.ready)
   `RAU_ASSERT(a_div_nonzero, clock, reset, div_start |-> (div_dvs != '0))
   `RAU_ASSERT(a_err_zero, clock, reset, (rsp_ch.valid && rsp_ch.error) |->
      ((rsp_ch.res_num == '0) && (rsp_ch.res_den == '0)))
   `RAU_ASSERT_ALWAYS(a_reset_idle, clock, reset |=> (state_ff == ST_IDLE))
endmodule

### test/testbench.sv
`timescale 1ns / 100ps

module testbench;
   import rau_pkg::*;

   localparam int W = 16;
   localparam int OW = 2 * W + 1;
   localparam int N_RANDOM = 1600;
   localparam longint CYCLE_LIMIT = 20000000;

   typedef struct packed {
      logic [2:0]         mode;
      logic signed [W-1:0] a_num;
      logic signed [W-1:0] a_den;
      logic signed [W-1:0] b_num;
      logic signed [W-1:0] b_den;
   } request_type;

   typedef struct packed {
      logic [OW-1:0] res_num;
      logic [OW-1:0] res_den;
      logic          error;
   } fraction_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   rau_req_if #(.WIDTH(W)) req_ch ();
   rau_rsp_if #(.WIDTH(W)) rsp_ch ();

   rational_arithmetic_unit #(.WIDTH(W)) u_dut (
      .clock (clock),
      .reset (reset),
      .req_ch(req_ch.sink),
      .rsp_ch(rsp_ch.source)
   );

   request_type  pending_requests[$];
   fraction_type expected_fractions[$];
   bit        stimulus_done = 1'b0;
   bit        hold_rsp = 1'b0;
   int        error_count = 0;
   longint    cycle_count = 0;

   always #1 clock = ~clock;

   // Pick a gap length: mostly zero or short, now and then long.
   function automatic int pick_gap();
      int r;
      r = $urandom_range(99);
      if (r < 50) return 0;
      if (r < 92) return $urandom_range(3, 1);
      return $urandom_range(40, 8);
   endfunction

   // Two's complement of a magnitude, cut to the result width.
   function automatic logic [OW-1:0] to_twos(bit neg, longint unsigned mag);
      longint unsigned v;
      v = neg ? (64'd0 - mag) : mag;
      return v[OW-1:0];
   endfunction

   // Reduced fraction of one request, worked on sign and magnitude.
   function automatic fraction_type reduce_fraction(request_type rq);
      fraction_type f;
      bit an_s, ad_s, bn_s, bd_s, n_s, d_s, g_s, p_s, q_s;
      longint unsigned an, ad, bn, bd, n, d, p, q, ga, gb, t;
      an_s = rq.a_num < 0; an = an_s ? -longint'(rq.a_num) : longint'(rq.a_num);
      ad_s = rq.a_den < 0; ad = ad_s ? -longint'(rq.a_den) : longint'(rq.a_den);
      bn_s = rq.b_num < 0; bn = bn_s ? -longint'(rq.b_num) : longint'(rq.b_num);
      bd_s = rq.b_den < 0; bd = bd_s ? -longint'(rq.b_den) : longint'(rq.b_den);
      f = '0;
      if (rq.mode == MODE_INC || rq.mode == MODE_DEC) begin
         d_s = (rq.mode == MODE_DEC) ? !ad_s : ad_s;
         if (an_s == d_s) begin
            n_s = an_s; n = an + ad;
         end else if (an >= ad) begin
            n_s = an_s; n = an - ad;
         end else begin
            n_s = d_s; n = ad - an;
         end
         f.res_num = to_twos(n_s && n != 0, n);
         f.res_den = to_twos(ad_s, ad);
         return f;
      end
      if (rq.mode > MODE_DEC) begin
         f.error = 1'b1;
         return f;
      end
      // Cross products.
      case (rq.mode)
         MODE_MUL: begin
            n = an * bn; n_s = an_s != bn_s;
            d = ad * bd; d_s = ad_s != bd_s;
         end
         MODE_DIV: begin
            n = an * bd; n_s = an_s != bd_s;
            d = ad * bn; d_s = ad_s != bn_s;
         end
         default: begin
            p = an * bd; p_s = (an_s != bd_s) && p != 0;
            q = bn * ad; q_s = (bn_s != ad_s) && q != 0;
            if (rq.mode == MODE_SUB) q_s = !q_s && q != 0;
            if (p_s == q_s) begin
               n_s = p_s; n = p + q;
            end else if (p >= q) begin
               n_s = p_s; n = p - q;
            end else begin
               n_s = q_s; n = q - p;
            end
            d = ad * bd; d_s = ad_s != bd_s;
         end
      endcase
      if (n == 0) n_s = 1'b0;
      if (d == 0) d_s = 1'b0;
      // Euclid loop: the sign of the divisor survives only if a single remainder step runs.
      ga = n; gb = d; g_s = n_s;
      if (gb != 0) begin
         g_s = d_s;
         while (gb != 0) begin
            t = ga % gb; ga = gb; gb = t;
            if (gb != 0) g_s = 1'b0;
         end
      end
      if (ga == 0) begin
         f.error = 1'b1;
         return f;
      end
      f.res_num = to_twos((n_s != g_s) && n / ga != 0, n / ga);
      f.res_den = to_twos((d_s != g_s) && d / ga != 0, d / ga);
      return f;
   endfunction

   function automatic request_type make_request(logic [2:0] m, int an, int ad, int bn, int bd);
      request_type r;
      r.mode = m; r.a_num = W'(an); r.a_den = W'(ad); r.b_num = W'(bn); r.b_den = W'(bd);
      return r;
   endfunction

   // Random operand: small values, extremes, or full range.
   function automatic logic [W-1:0] rand_operand();
      int r;
      r = $urandom_range(9);
      if (r < 4) return W'($urandom_range(30) - 15);
      if (r == 4) return ($urandom_range(1)) ? 16'sh7fff : 16'sh8000;
      if (r == 5) return 0;
      return W'($urandom());
   endfunction

   // Stimulus: directed cases then random ones.
   initial begin
      request_type r;
      pending_requests.push_back(make_request(MODE_ADD, 1, 2, 1, 3));
      pending_requests.push_back(make_request(MODE_SUB, 1, 2, 1, 2));
      pending_requests.push_back(make_request(MODE_MUL, 0, 5, 3, 0));
      pending_requests.push_back(make_request(MODE_DIV, 3, 4, 0, 7));
      pending_requests.push_back(make_request(MODE_ADD, 5, 0, 3, 0));
      pending_requests.push_back(make_request(MODE_MUL, 6, 4, 2, 3));
      pending_requests.push_back(make_request(MODE_DIV, -6, 4, 3, -8));
      pending_requests.push_back(make_request(MODE_MUL, -32768, -32768, -32768, -32768));
      pending_requests.push_back(make_request(MODE_ADD, 32767, -32768, -32768, 32767));
      pending_requests.push_back(make_request(MODE_SUB, -32768, 32767, 32767, -32768));
      pending_requests.push_back(make_request(MODE_DIV, 32767, -1, -32768, 1));
      pending_requests.push_back(make_request(MODE_INC, 32767, 32767, 0, 0));
      pending_requests.push_back(make_request(MODE_DEC, -32768, 32767, -1, -1));
      pending_requests.push_back(make_request(MODE_INC, 5, 0, 1, 1));
      pending_requests.push_back(make_request(MODE_DEC, 3, -7, 0, 0));
      pending_requests.push_back(make_request(3'd6, 1, 2, 3, 4));
      pending_requests.push_back(make_request(3'd7, -1, -1, -1, -1));
      pending_requests.push_back(make_request(MODE_MUL, 4, -6, -3, 9));
      pending_requests.push_back(make_request(MODE_ADD, 0, 0, 0, 0));
      for (int i = 0; i < N_RANDOM; i++) begin
         r.mode = ($urandom_range(19) == 0) ? 3'($urandom_range(7, 6)) : 3'($urandom_range(5));
         r.a_num = rand_operand(); r.a_den = rand_operand();
         r.b_num = rand_operand(); r.b_den = rand_operand();
         pending_requests.push_back(r);
      end
      stimulus_done = 1'b1;
   end

   task automatic r_drive(request_type r);
      req_ch.valid <= 1'b1;
      req_ch.mode  <= r.mode;
      req_ch.a_num <= r.a_num;
      req_ch.a_den <= r.a_den;
      req_ch.b_num <= r.b_num;
      req_ch.b_den <= r.b_den;
   endtask

   // Request driver.
   int send_gap = 0;
   always @(posedge clock) begin
      if (reset) begin
         req_ch.valid <= 1'b0;
         req_ch.mode  <= '0;
         req_ch.a_num <= '0;
         req_ch.a_den <= '0;
         req_ch.b_num <= '0;
         req_ch.b_den <= '0;
      end else begin
         if (req_ch.valid && req_ch.ready) begin
            expected_fractions.push_back(reduce_fraction({req_ch.mode, req_ch.a_num,
               req_ch.a_den, req_ch.b_num, req_ch.b_den}));
            send_gap = pick_gap();
         end
         if (!req_ch.valid || req_ch.ready) begin
            if (send_gap > 0 || pending_requests.size() == 0) begin
               if (send_gap > 0) send_gap--;
               req_ch.valid <= 1'b0;
            end else begin
               r_drive(pending_requests.pop_front());
            end
         end
      end
   end

   // Receiver stalls, with one long hold-off early in the random part.
   int stall_left = 0;
   int accepted_rsp = 0;
   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else begin
         if (accepted_rsp == 30 && !hold_rsp) begin
            hold_rsp = 1'b1;
            stall_left = 3000;
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_ch.ready <= 1'b0;
         end else if (accepted_rsp > 200 && accepted_rsp < 400) begin
            rsp_ch.ready <= 1'b1;
         end else begin
            stall_left = pick_gap();
            rsp_ch.ready <= (stall_left == 0);
         end
      end
   end

   // Response checker.
   always @(posedge clock) begin
      fraction_type e;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         accepted_rsp++;
         if (expected_fractions.size() == 0) begin
            $error("unexpected response %0d/%0d", rsp_ch.res_num, rsp_ch.res_den);
            error_count++;
         end else begin
            e = expected_fractions.pop_front();
            if (rsp_ch.res_num !== e.res_num) begin
               $error("res_num: expected %h, got %h", e.res_num, rsp_ch.res_num);
               error_count++;
            end
            if (rsp_ch.res_den !== e.res_den) begin
               $error("res_den: expected %h, got %h", e.res_den, rsp_ch.res_den);
               error_count++;
            end
            if (rsp_ch.error !== e.error) begin
               $error("error: expected %b, got %b", e.error, rsp_ch.error);
               error_count++;
            end
         end
      end
   end

   // Reset, end of run and cycle limit.
   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      while (!(stimulus_done && pending_requests.size() == 0 && !req_ch.valid
               && expected_fractions.size() == 0))
         @(posedge clock);
      repeat (50) @(posedge clock);
      if (error_count == 0 && expected_fractions.size() == 0)
         $display("testbench: done, clean");
      else
         $display("testbench: done, errors");
      $finish;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("testbench: done, errors");
         $finish;
      end
   end

endmodule
